/* src/smpq_pkg.sv */
// Shared types, codes and widths of the stable max priority queue.
package smpq_pkg;

    localparam int PRIO_W        = 16;
    localparam int DATA_W        = 8;
    localparam int FILL_W        = 5;
    localparam int DEFAULT_DEPTH = 16;

    // Action codes carried on the input tuser
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Status codes carried on the output tuser
    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_REMOVED  = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // One queue entry as stored in the slot memory
    typedef struct packed {
        logic [DATA_W-1:0]        data;
        logic signed [PRIO_W-1:0] prio;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Control of the shared comparator for one scan word
    typedef struct packed {
        logic valid;
        logic first;
    } cmp_ctl_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

endpackage

/* src/smpq_ram.sv */
// Generic simple dual-port RAM with registered read.
module smpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/smpq_best.sv */
// Shared comparator that tracks the highest priority seen during a scan.
module smpq_best import smpq_pkg::*; #(
    parameter int AW = 4
) (
    input  logic          clk,
    input  cmp_ctl_t      ctl,
    input  logic [AW-1:0] idx,
    input  entry_t        cand,
    output logic [AW-1:0] best_idx,
    output entry_t        best
);

    logic [AW-1:0] best_idx_reg;
    entry_t        best_reg;
    logic          take;

    // Strictly greater keeps the earliest slot on a tie
    assign take = ctl.valid && (ctl.first || (cand.prio > best_reg.prio));

    // Hold the current winner
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= idx;
            best_reg     <= cand;
        end
    end

    assign best_idx = best_idx_reg;
    assign best     = best_reg;

endmodule

/* src/stable_max_priority_queue_top.sv */
// Top level of the stable max priority queue: sequencer, slot memory and output register.
//
// A bounded queue of DEPTH entries, each a signed 16-bit priority and a data byte, kept
// packed from slot 0 upward in a single-port-read slot RAM. Every input word gives exactly
// one result word. An insert, an insert into a full queue and a remove from an empty queue
// have their result registered in the cycle the word is accepted. A remove scans all held
// entries through the one shared comparator, shifts the later entries down one slot and
// then posts the result; the one RAM read port paces the scan and the shift. Ties go to the
// earliest inserted entry. No clearing pass follows reset. A new word is taken only while
// the sequencer is idle and the output register is free or being drained.
module stable_max_priority_queue_top import smpq_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] item_priority, [23:16] item_data
    input  logic [0:0]  s_tuser,   // [0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] out_priority, [23:16] out_data,
                                   // [28:24] fill_level, [31:29] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          rvalid_reg, rvalid_next;
    logic [AW-1:0] ridx_reg, ridx_next;

    logic              m_valid_reg, m_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [PRIO_W-1:0] oprio_reg, oprio_next;
    logic [DATA_W-1:0] odata_reg, odata_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic                 accept, out_free, issue;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata, ram_rdata, in_entry, best;
    logic [AW-1:0]        best_idx;
    cmp_ctl_t             cmp_ctl;
    logic [CW+FILL_W-1:0] count_wide;

    assign in_entry.prio = s_tdata[15:0];
    assign in_entry.data = s_tdata[23:16];
    assign accept        = s_tvalid && s_tready;
    assign out_free      = !m_valid_reg || m_tready;
    assign issue         = (ptr_reg < count_reg) &&
                           (state_reg == S_SCAN || state_reg == S_SHIFT);
    assign count_wide    = {{FILL_W{1'b0}}, count_next};
    assign fill_next     = count_wide[FILL_W-1:0];

    // Feed the comparator only with scan words
    assign cmp_ctl.valid = rvalid_reg && (state_reg == S_SCAN);
    assign cmp_ctl.first = (ridx_reg == '0);

    smpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    smpq_best #(
        .AW (AW)
    ) u_best (
        .clk      (clk),
        .ctl      (cmp_ctl),
        .idx      (ridx_reg),
        .cand     (ram_rdata),
        .best_idx (best_idx),
        .best     (best)
    );

    // Sequence inserts, scans, compaction and result posting
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        rvalid_next  = issue;
        ridx_next    = ptr_reg[AW-1:0];
        m_valid_next = m_valid_reg && !m_tready;
        status_next  = status_reg;
        oprio_next   = oprio_reg;
        odata_next   = odata_reg;
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[AW-1:0];
        ram_wdata    = in_entry;

        case (state_reg)
            S_IDLE:
            begin
                s_tready = out_free;
                if (s_tvalid && out_free)
                begin
                    oprio_next = '0;
                    odata_next = '0;
                    if (s_tuser[0] == ACT_INSERT)
                    begin
                        m_valid_next = 1'b1;
                        if (count_reg == FULL_COUNT)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_INSERTED;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        m_valid_next = 1'b1;
                        status_next  = ST_EMPTY;
                    end
                    else
                    begin
                        ptr_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                else if (!rvalid_reg)
                begin
                    ptr_next   = {{(CW-AW){1'b0}}, best_idx} + 1'b1;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (issue)
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
                // Move each later entry down one slot
                if (rvalid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ridx_reg - 1'b1;
                    ram_wdata = ram_rdata;
                end
                if (!issue && !rvalid_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    status_next  = ST_REMOVED;
                    oprio_next   = best.prio;
                    odata_next   = best.data;
                    count_next   = count_reg - 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            ptr_reg     <= '0;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            rvalid_reg  <= rvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold the read index and result payload
    always_ff @(posedge clk)
    begin
        ridx_reg <= ridx_next;
        if (m_valid_next && out_free)
        begin
            status_reg <= status_next;
            oprio_reg  <= oprio_next;
            odata_reg  <= odata_next;
            fill_reg   <= fill_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, fill_reg, odata_reg, oprio_reg};

    // The fill count never passes the queue depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count above depth");

    // Input is taken only while the sequencer is idle
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (state_reg == S_IDLE))
        else $error("ready outside idle");

    // The slot memory is written only by an accepted insert or by compaction
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((accept && s_tuser[0] == ACT_INSERT) || state_reg == S_SHIFT))
        else $error("unexpected slot write");

    // Posting a removal drops the count by one
    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=>
        (count_reg == $past(count_reg) - 1'b1))
        else $error("removal did not decrement count");

    // A scan starts only on a non-empty queue
    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (count_reg != '0))
        else $error("scan of empty queue");

endmodule
